// ----- hw/rtl/gds_pkg.sv -----
// Shared constants, types and helpers of the decimating graph smoother.
`default_nettype none

package gds_pkg;

    // Character codes
    localparam logic signed [7:0] CODE_A = 8'sd97;
    localparam logic signed [7:0] CODE_Z = 8'sd122;

    // Window shape
    localparam int unsigned TAPS      = 9;
    localparam int unsigned HIST      = TAPS - 1;
    localparam logic [3:0]  FILL_FULL = 4'd8;
    localparam logic [1:0]  PHASE_RELOAD = 2'd2;   // stride of 3, minus one

    // Weighted sum of nine offsets in -225..30 stays within +/-8100
    localparam int unsigned SUM_W = 14;

    // Round half away from zero on |S| / 36: add 18, divide by 4, then by 9
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(18);
    localparam int unsigned      QTR_W      = SUM_W - 2;
    localparam int unsigned      RECIP_SH   = 16;
    localparam logic [RECIP_SH-1:0] RECIP_9 = 16'd7282;   // ceil(2^16 / 9)
    localparam int unsigned      PROD_W     = QTR_W + RECIP_SH;
    localparam int unsigned      QUO_W      = 9;

    // Tap weights, oldest code first
    localparam logic [2:0] TAP_WEIGHT [TAPS] = '{3'd1, 3'd3, 3'd5, 3'd6, 3'd6,
                                                 3'd6, 3'd5, 3'd3, 3'd1};

    // Result of the rounding stage
    typedef struct packed {
        logic signed [7:0] code;   // clamped character
        logic              zero;   // window rounded to zero
    } t_round_res;

    // One weighted tap: weight * (code - 'a')
    function automatic logic signed [SUM_W-1:0] tap_term(
        input logic signed [7:0] code,
        input logic [2:0]        weight
    );
        logic signed [SUM_W-1:0] diff;
        logic signed [SUM_W-1:0] wgt;
        diff = SUM_W'(code) - SUM_W'(CODE_A);
        wgt  = SUM_W'($signed({1'b0, weight}));
        return SUM_W'(diff * wgt);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gds_round.sv -----
// Rounding divide by 36, offset by 'a', wrap and clamp of one window sum.
`default_nettype none

module gds_round
    import gds_pkg::*;
(
    input  wire logic signed [SUM_W-1:0] i_sum,
    output t_round_res                   o_res
);

    logic                     neg;
    logic [SUM_W-1:0]         mag;
    logic [SUM_W-1:0]         biased;
    logic [QTR_W-1:0]         quarter;
    logic [PROD_W-1:0]        prod;
    logic [QUO_W-1:0]         quo;
    logic signed [QUO_W:0]    value;
    logic signed [QUO_W:0]    shifted;
    logic signed [7:0]        wrapped;

    // Magnitude, bias by half the divisor, drop two bits
    always_comb begin
        neg     = i_sum[SUM_W-1];
        mag     = neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        biased  = mag + ROUND_BIAS;
        quarter = biased[SUM_W-1:2];
    end

    // Divide by nine with a reciprocal multiply
    always_comb begin
        prod = PROD_W'(quarter) * PROD_W'(RECIP_9);
        quo  = prod[RECIP_SH +: QUO_W];
    end

    // Restore sign, add 'a', wrap to 8 bits and clamp to 'z'
    always_comb begin
        value   = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        shifted = value + (QUO_W+1)'(CODE_A);
        wrapped = $signed(shifted[7:0]);
        o_res.code = (wrapped > CODE_Z) ? CODE_Z : wrapped;
        o_res.zero = (quo == '0);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/graph_decimating_smoother_core.sv -----
// Top level of the decimating graph smoother: window, sum stage and result register.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] in_code, tlast in_last
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[7:0] out_code,
//                                                tuser[0] out_valid, tlast out_end
//
// One beat per cycle is accepted while the output is not stalled; a result passes the sum
// register and then the result register on its way out.
// i_rst_n is synchronous and active low; it empties both stages and clears
// the fill count, stride phase and stop flag.
// A stalled result register holds the sum stage, and that holds s_axis_tready low.
`default_nettype none

module graph_decimating_smoother_core
    import gds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_code
    input  wire logic       s_axis_tlast,   // in_last

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_code
    output logic [0:0]      m_axis_tuser,   // [0] out_valid
    output logic            m_axis_tlast    // out_end
);

    // Code history, index HIST-1 newest
    logic signed [7:0]        r_win [HIST];
    logic [3:0]               r_fill;
    logic [3:0]               n_fill;
    logic [1:0]               r_phase;
    logic [1:0]               n_phase;
    logic                     n_eval;

    // Sum stage
    logic                     r_s1_vld;
    logic                     r_s1_eval;
    logic                     r_s1_last;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic signed [SUM_W-1:0]  n_sum;

    // Result stage
    logic                     r_stopped;
    logic                     n_stopped;
    logic                     r_o_vld;
    logic signed [7:0]        r_o_code;
    logic                     r_o_have;
    logic                     r_o_last;
    logic                     n_have;
    logic                     n_emit;

    logic                     in_beat;
    logic                     o_free;
    logic                     s1_adv;
    logic signed [7:0]        in_code;
    t_round_res               rnd;

    assign in_code = $signed(s_axis_tdata);

    // Handshake
    assign o_free        = !r_o_vld || m_axis_tready;
    assign s1_adv        = r_s1_vld && o_free;
    assign s_axis_tready = !r_s1_vld || o_free;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Fill count and stride phase: evaluate every third code once full; an end beat clears both
    always_comb begin
        n_fill  = r_fill;
        n_phase = r_phase;
        n_eval  = 1'b0;
        if (r_fill >= FILL_FULL) begin
            if (r_phase == 2'd0) begin
                n_eval  = 1'b1;
                n_phase = PHASE_RELOAD;
            end else begin
                n_phase = r_phase - 2'd1;
            end
        end else begin
            n_fill = r_fill + 4'd1;
        end
        if (s_axis_tlast) begin
            n_fill  = '0;
            n_phase = '0;
        end
    end

    // Weighted window sum over history plus the incoming code
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < HIST; i++) begin
            n_sum = n_sum + tap_term(r_win[i], TAP_WEIGHT[i]);
        end
        n_sum = n_sum + tap_term(in_code, TAP_WEIGHT[TAPS-1]);
    end

    // Advance the history on each input beat
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            for (int i = 0; i < HIST - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[HIST-1] <= in_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_phase <= '0;
        end else if (in_beat) begin
            r_fill  <= n_fill;
            r_phase <= n_phase;
        end
    end

    // Load the sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_eval <= n_eval;
            r_s1_last <= s_axis_tlast;
            r_s1_sum  <= n_sum;
        end
    end

    gds_round u_round (
        .i_sum (r_s1_sum),
        .o_res (rnd)
    );

    // Stop flag: first zero window drops the rest of the stream
    always_comb begin
        n_have    = 1'b0;
        n_stopped = r_stopped;
        if (r_s1_eval && !r_stopped) begin
            if (rnd.zero) begin
                n_stopped = 1'b1;
            end else begin
                n_have = 1'b1;
            end
        end
        if (r_s1_last) begin
            n_stopped = 1'b0;
        end
        n_emit = n_have || r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
        end else if (s1_adv) begin
            r_stopped <= n_stopped;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_free) begin
            r_o_vld <= s1_adv && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && n_emit) begin
            r_o_code <= n_have ? rnd.code : 8'sd0;
            r_o_have <= n_have;
            r_o_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid   = r_o_vld;
    assign m_axis_tdata    = r_o_code;
    assign m_axis_tuser[0] = r_o_have;
    assign m_axis_tlast    = r_o_last;

endmodule

`default_nettype wire

// ----- hw/rtl/gds_checker.sv -----
// Port-level checks of the decimating graph smoother, bound to its top level.
`default_nettype none

module gds_checker
    import gds_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [0:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Produced characters never exceed 'z'
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> $signed(m_axis_tdata) <= CODE_Z)
        else $error("produced character above clamp");

    // A beat without a character is always the end marker, with zero code
    a_empty_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("empty result beat that is not an end marker");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // An input beat passes the sum register and the result register before it can reach the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!s_axis_tvalid, 1) && $past(!s_axis_tvalid, 2) && !$past(m_axis_tvalid, 1)
            && $past(i_rst_n, 2) |-> !m_axis_tvalid)
        else $error("result appeared without an input beat");

endmodule

bind graph_decimating_smoother_core gds_checker u_gds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
